FILE: design/prefix_code_tree_decoder_defines.svh
// Assertion macros shared by the prefix-code tree decoder.
`ifndef PREFIX_CODE_TREE_DECODER_DEFINES_SVH
`define PREFIX_CODE_TREE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define PCTD_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

`define PCTD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`define PCTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define PCTD_ASSERT_HOLDS(label, clk, rst_n, cond)
`define PCTD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PCTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/pctd_pkg.sv
// Types, constants and codes of the prefix-code tree decoder.
package pctd_pkg;

    localparam int NODE_COUNT   = 512;
    localparam int NODE_BITS    = $clog2(NODE_COUNT);
    localparam int USED_BITS    = $clog2(NODE_COUNT + 1);
    localparam int MAX_CODE_LEN = 16;
    localparam int CODE_BITS    = 16;
    localparam int POS_BITS     = $clog2(CODE_BITS);
    localparam int LEN_BITS     = 5;
    localparam int SYMBOL_BITS  = 8;
    localparam int SYM_IO_BITS  = 8;
    localparam int STATUS_BITS  = 3;
    localparam int S_DATA_BITS  = 32;
    localparam int M_DATA_BITS  = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_SYMBOL   = 3'd1,
        ST_FULL     = 3'd2,
        ST_MISSING  = 3'd3,
        ST_CONFLICT = 3'd4
    } status_t;

    typedef struct packed {
        logic                       leaf;
        logic [SYMBOL_BITS-1:0]     sym;
        logic [1:0][NODE_BITS-1:0]  kid;
    } node_t;

    typedef struct packed {
        logic                   rd_en;
        logic [NODE_BITS-1:0]   rd_addr;
        logic                   wr_en;
        logic [NODE_BITS-1:0]   wr_addr;
        node_t                  wr_data;
    } store_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_NEW,
        S_INS_END,
        S_DEC_KID,
        S_DEC_LEAF,
        S_DONE
    } seq_state_t;

endpackage

FILE: design/pctd_node_store.sv
// Node store: root node in flip-flops, remaining nodes in a one-read one-write memory.
module pctd_node_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pctd_pkg::store_req_t req,
    output pctd_pkg::node_t      rdata
);

    pctd_pkg::node_t mem [pctd_pkg::NODE_COUNT];
    pctd_pkg::node_t mem_q_reg;
    pctd_pkg::node_t root_reg;
    logic            rd_root_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en && (req.wr_addr != '0)) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            mem_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= '0;
            rd_root_reg <= 1'b1;
        end else begin
            if (req.wr_en && (req.wr_addr == '0)) begin
                root_reg <= req.wr_data;
            end
            if (req.rd_en) begin
                rd_root_reg <= (req.rd_addr == '0);
            end
        end
    end

    assign rdata = rd_root_reg ? root_reg : mem_q_reg;

endmodule

FILE: design/pctd_walk_seq.sv
// Walk sequencer: steps inserts and decodes through the node store and holds the result.
module pctd_walk_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [pctd_pkg::CODE_BITS-1:0]      code_bits,
    input  logic [pctd_pkg::LEN_BITS-1:0]       code_length,
    input  logic [pctd_pkg::SYM_IO_BITS-1:0]    symbol_in,
    input  logic                                data_bit,
    output pctd_pkg::store_req_t                req,
    input  pctd_pkg::node_t                     rdata,
    output logic                                res_valid,
    input  logic                                res_ready,
    output pctd_pkg::status_t                   res_status,
    output logic [pctd_pkg::SYM_IO_BITS-1:0]    res_symbol
);

    pctd_pkg::seq_state_t                   state_reg, state_next;
    logic [pctd_pkg::CODE_BITS-1:0]         code_reg, code_next;
    logic [pctd_pkg::LEN_BITS-1:0]          len_reg, len_next;
    logic [pctd_pkg::LEN_BITS-1:0]          idx_reg, idx_next;
    logic [pctd_pkg::SYMBOL_BITS-1:0]       sym_reg, sym_next;
    logic                                   bit_reg, bit_next;
    logic [pctd_pkg::NODE_BITS-1:0]         cur_reg, cur_next;
    logic [pctd_pkg::NODE_BITS-1:0]         walk_reg, walk_next;
    logic [pctd_pkg::USED_BITS-1:0]         used_reg, used_next;
    pctd_pkg::status_t                      pend_status_reg, pend_status_next;
    logic [pctd_pkg::SYMBOL_BITS-1:0]       pend_sym_reg, pend_sym_next;
    logic                                   out_valid_reg, out_valid_next;
    pctd_pkg::status_t                      out_status_reg, out_status_next;
    logic [pctd_pkg::SYM_IO_BITS-1:0]       out_sym_reg, out_sym_next;

    logic [pctd_pkg::LEN_BITS-1:0]          pos;
    logic                                   step_bit;
    logic [pctd_pkg::NODE_BITS-1:0]         kid;
    logic [pctd_pkg::USED_BITS:0]           need_sum;
    logic                                   full;
    logic [pctd_pkg::NODE_BITS-1:0]         new_node;
    pctd_pkg::node_t                        wr_node;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pctd_pkg::S_IDLE;
            walk_reg      <= '0;
            used_reg      <= pctd_pkg::USED_BITS'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg        <= code_next;
        len_reg         <= len_next;
        idx_reg         <= idx_next;
        sym_reg         <= sym_next;
        bit_reg         <= bit_next;
        cur_reg         <= cur_next;
        pend_status_reg <= pend_status_next;
        pend_sym_reg    <= pend_sym_next;
        out_status_reg  <= out_status_next;
        out_sym_reg     <= out_sym_next;
    end

    assign pos      = len_reg - idx_reg - pctd_pkg::LEN_BITS'(1);
    assign step_bit = (int'(pos) < pctd_pkg::CODE_BITS) ?
                      code_reg[pos[pctd_pkg::POS_BITS-1:0]] : 1'b0;
    assign need_sum = {1'b0, used_reg} + (pctd_pkg::USED_BITS + 1)'(len_reg - idx_reg);
    assign full     = need_sum > (pctd_pkg::USED_BITS + 1)'(pctd_pkg::NODE_COUNT);
    assign new_node = used_reg[pctd_pkg::NODE_BITS-1:0];

    always_comb begin
        state_next       = state_reg;
        code_next        = code_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        sym_next         = sym_reg;
        bit_next         = bit_reg;
        cur_next         = cur_reg;
        walk_next        = walk_reg;
        used_next        = used_reg;
        pend_status_next = pend_status_reg;
        pend_sym_next    = pend_sym_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        out_status_next  = out_status_reg;
        out_sym_next     = out_sym_reg;
        req              = '0;
        in_ready         = 1'b0;
        kid              = '0;
        wr_node          = '0;

        unique case (state_reg)
            pctd_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    code_next     = code_bits;
                    len_next      = code_length;
                    sym_next      = pctd_pkg::SYMBOL_BITS'(symbol_in);
                    bit_next      = data_bit;
                    idx_next      = '0;
                    pend_sym_next = '0;
                    if (opcode == pctd_pkg::OP_DECODE) begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = walk_reg;
                        cur_next    = walk_reg;
                        state_next  = pctd_pkg::S_DEC_KID;
                    end else if ((code_length == '0) ||
                                 (int'(code_length) > pctd_pkg::MAX_CODE_LEN)) begin
                        pend_status_next = pctd_pkg::ST_CONFLICT;
                        state_next       = pctd_pkg::S_DONE;
                    end else begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = '0;
                        cur_next    = '0;
                        state_next  = pctd_pkg::S_INS_CHK;
                    end
                end
            end
            pctd_pkg::S_INS_CHK: begin
                kid = rdata.kid[step_bit];
                if (rdata.leaf) begin
                    pend_status_next = pctd_pkg::ST_CONFLICT;
                    state_next       = pctd_pkg::S_DONE;
                end else if (kid != '0) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = kid;
                    cur_next    = kid;
                    idx_next    = idx_reg + pctd_pkg::LEN_BITS'(1);
                    if ((idx_reg + pctd_pkg::LEN_BITS'(1)) == len_reg) begin
                        state_next = pctd_pkg::S_INS_END;
                    end
                end else if (full) begin
                    pend_status_next = pctd_pkg::ST_FULL;
                    state_next       = pctd_pkg::S_DONE;
                end else begin
                    wr_node               = rdata;
                    wr_node.kid[step_bit] = new_node;
                    req.wr_en             = 1'b1;
                    req.wr_addr           = cur_reg;
                    req.wr_data           = wr_node;
                    cur_next              = new_node;
                    used_next             = used_reg + pctd_pkg::USED_BITS'(1);
                    idx_next              = idx_reg + pctd_pkg::LEN_BITS'(1);
                    state_next            = pctd_pkg::S_INS_NEW;
                end
            end
            pctd_pkg::S_INS_NEW: begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_reg;
                if (idx_reg == len_reg) begin
                    wr_node.leaf     = 1'b1;
                    wr_node.sym      = sym_reg;
                    req.wr_data      = wr_node;
                    pend_status_next = pctd_pkg::ST_OK;
                    state_next       = pctd_pkg::S_DONE;
                end else begin
                    wr_node.kid[step_bit] = new_node;
                    req.wr_data           = wr_node;
                    cur_next              = new_node;
                    used_next             = used_reg + pctd_pkg::USED_BITS'(1);
                    idx_next              = idx_reg + pctd_pkg::LEN_BITS'(1);
                end
            end
            pctd_pkg::S_INS_END: begin
                if ((rdata.kid[0] != '0) || (rdata.kid[1] != '0)) begin
                    pend_status_next = pctd_pkg::ST_CONFLICT;
                end else begin
                    wr_node.leaf     = 1'b1;
                    wr_node.sym      = sym_reg;
                    req.wr_en        = 1'b1;
                    req.wr_addr      = cur_reg;
                    req.wr_data      = wr_node;
                    pend_status_next = pctd_pkg::ST_OK;
                end
                state_next = pctd_pkg::S_DONE;
            end
            pctd_pkg::S_DEC_KID: begin
                kid = rdata.kid[bit_reg];
                if (kid == '0) begin
                    pend_status_next = pctd_pkg::ST_MISSING;
                    walk_next        = '0;
                    state_next       = pctd_pkg::S_DONE;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = kid;
                    cur_next    = kid;
                    state_next  = pctd_pkg::S_DEC_LEAF;
                end
            end
            pctd_pkg::S_DEC_LEAF: begin
                if (rdata.leaf) begin
                    pend_status_next = pctd_pkg::ST_SYMBOL;
                    pend_sym_next    = rdata.sym;
                    walk_next        = '0;
                end else begin
                    pend_status_next = pctd_pkg::ST_OK;
                    walk_next        = cur_reg;
                end
                state_next = pctd_pkg::S_DONE;
            end
            pctd_pkg::S_DONE: begin
                if (!out_valid_reg || res_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_sym_next    = pctd_pkg::SYM_IO_BITS'(pend_sym_reg);
                    state_next      = pctd_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pctd_pkg::S_IDLE;
            end
        endcase
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_symbol = out_sym_reg;

endmodule

FILE: design/prefix_code_tree_decoder.sv
// Top level of the prefix-code tree decoder: stream ports, sequencer and node store.
//
// Builds a binary code tree in a 512-node store and decodes a bit stream with it; every
// input transfer gives exactly one result transfer. All node reads and writes go through
// the single read port and single write port of the node store, one access per cycle,
// and the read data is registered, so each tree level takes its own store access. A
// decode transfer reads the current node, reads the child and then presents the result;
// when the child is missing it presents the result without the second read. An insert
// with a bad length goes straight to presenting its result without touching the store;
// any other insert walks the code one level per store access and stops early on a
// conflict or a full store. s_tready is high from the edge that loads the result. The
// next input is taken as soon as the result is in the output register, even while that
// result still waits for m_tready; the following result then waits in the sequencer
// until the first is taken, and the input stalls meanwhile. The store needs no clearing
// pass after reset: nodes are handed out in order from a fill count, each new node is
// written whole in the cycle after its parent link and before any read can reach it, and
// the root node sits in flip-flops cleared by reset.
`include "prefix_code_tree_decoder_defines.svh"

module prefix_code_tree_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] code_bits, [20:16] code_length, [28:21] symbol_in, [29] data_bit
    input  logic [pctd_pkg::S_DATA_BITS-1:0]    s_tdata,
    // [0] opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] status, [10:3] symbol_out
    output logic [pctd_pkg::M_DATA_BITS-1:0]    m_tdata
);

    pctd_pkg::store_req_t                   store_req;
    pctd_pkg::node_t                        store_rdata;
    pctd_pkg::status_t                      res_status;
    logic [pctd_pkg::SYM_IO_BITS-1:0]       res_symbol;

    pctd_walk_seq u_walk_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .opcode      (s_tuser),
        .code_bits   (s_tdata[15:0]),
        .code_length (s_tdata[20:16]),
        .symbol_in   (s_tdata[28:21]),
        .data_bit    (s_tdata[29]),
        .req         (store_req),
        .rdata       (store_rdata),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_status  (res_status),
        .res_symbol  (res_symbol)
    );

    pctd_node_store u_node_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rdata   (store_rdata)
    );

    assign m_tdata = {5'b0, res_symbol, res_status};

    `PCTD_ASSERT_HOLDS(a_store_one_access, aclk, aresetn,
                       !(store_req.rd_en && store_req.wr_en))
    `PCTD_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `PCTD_ASSERT_IMPLIES(a_symbol_only_on_emit, aclk, aresetn,
                         m_tvalid && (res_status != pctd_pkg::ST_SYMBOL), res_symbol == '0)

endmodule
